// ===== src/rvattr_pkg.sv =====
package rvattr_pkg;

  typedef enum logic [3:0] {
    PH_FORMAT = 4'd0,
    PH_SECLEN = 4'd1,
    PH_VENDOR = 4'd2,
    PH_SUBTAG = 4'd3,
    PH_SUBLEN = 4'd4,
    PH_TAG    = 4'd5,
    PH_STRING = 4'd6,
    PH_ULEB   = 4'd7
  } phase_t;

  typedef enum logic [2:0] {
    K_VCHAR   = 3'd0,
    K_VEND    = 3'd1,
    K_SCHAR   = 3'd2,
    K_SEND    = 3'd3,
    K_NUM     = 3'd4,
    K_ERR     = 3'd5,
    K_ENDONLY = 3'd6,
    K_NONE    = 3'd7
  } kind_t;

  localparam logic [7:0] CFG_LITTLE_ENDIAN = 8'd0;
  localparam logic [7:0] CFG_ARCH_TAG      = 8'd1;

  localparam logic [7:0] FORMAT_BYTE   = 8'h41;
  localparam logic [31:0] MIN_SUB_LEN  = 32'd5;
  localparam logic [6:0] ULEB_STEP     = 7'd7;

  localparam int OUT_DATA_W = 88;

endpackage

// ===== src/riscv_attribute_section_parser.sv =====
// RISC-V attributes section parser.
// Input stream: one section byte per item (in_tdata), in_tlast on the final
// byte. Output stream: at most one result item per input item, kind in
// out_tuser, section_end in out_tlast, the other fields in out_tdata.
// Config channel: cfg_index 0 = little_endian, 1 = arch_tag; other indexes
// are accepted and ignored. cfg_ready is always high; write only when idle.
// A result is registered and shows on out_tvalid in the cycle after its
// input item is accepted. Throughput: one input item per cycle unless the
// output stalls, set by the single state update before the output register.
// When the receiver stalls, the output register holds its item and
// in_tready drops until it is taken; an input item that gives no result
// still needs a free output slot in that cycle.
// Reset (rst_n low, synchronous) returns the parser to expecting the format
// byte and the registers to little_endian = 1, arch_tag = 5. After the item
// with in_tlast the parse state returns to reset, registers are kept.
module riscv_attribute_section_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [rvattr_pkg::OUT_DATA_W-1:0] out_tdata,
  // tag_id[7:0], char_out[15:8], num_value[79:16], sub_tag[87:80]
  output logic [2:0]  out_tuser,  // kind[2:0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import rvattr_pkg::*;

  logic        le_r;
  logic [7:0]  arch_tag_r;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  fbc_r, fbc_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [7:0]  subtag_r, subtag_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [6:0]  vshift_r, vshift_nxt;
  logic        halted_r, halted_nxt;

  logic        out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [2:0]  out_kind_r;
  logic        out_last_r;

  kind_t       kind;
  logic [7:0]  tag_o, ch_o;
  logic [63:0] val_o;
  logic [7:0]  b;
  logic        in_acc;
  logic        emit;

  assign b         = in_tdata;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign emit      = (kind != K_NONE);

  always_comb begin
    phase_nxt  = phase_r;
    fbc_nxt    = fbc_r;
    len_nxt    = len_r;
    rem_nxt    = rem_r;
    tag_nxt    = tag_r;
    subtag_nxt = subtag_r;
    acc_nxt    = acc_r;
    vshift_nxt = vshift_r;
    halted_nxt = halted_r;
    kind       = K_NONE;
    tag_o      = 8'd0;
    ch_o       = 8'd0;
    val_o      = 64'd0;

    if (!halted_r) begin
      unique case (phase_r)
        PH_FORMAT: begin
          if (b == FORMAT_BYTE) begin
            phase_nxt = PH_SECLEN;
            fbc_nxt   = 3'd0;
          end else begin
            kind       = K_ERR;
            halted_nxt = 1'b1;
          end
        end
        PH_SECLEN: begin
          fbc_nxt = fbc_r + 3'd1;
          if (fbc_nxt[2]) begin
            fbc_nxt   = 3'd0;
            phase_nxt = PH_VENDOR;
          end
        end
        PH_VENDOR: begin
          if (b != 8'd0) begin
            kind = K_VCHAR;
            ch_o = b;
          end else begin
            kind      = K_VEND;
            phase_nxt = PH_SUBTAG;
          end
        end
        PH_SUBTAG: begin
          subtag_nxt = b;
          len_nxt    = 32'd0;
          fbc_nxt    = 3'd0;
          phase_nxt  = PH_SUBLEN;
        end
        PH_SUBLEN: begin
          if (le_r)
            len_nxt = len_r | ({24'd0, b} << {fbc_r[1:0], 3'b000});
          else
            len_nxt = {len_r[23:0], b};
          fbc_nxt = fbc_r + 3'd1;
          if (fbc_nxt[2]) begin
            fbc_nxt = 3'd0;
            if (len_nxt < MIN_SUB_LEN) begin
              kind       = K_ERR;
              halted_nxt = 1'b1;
            end else begin
              rem_nxt   = len_nxt - MIN_SUB_LEN;
              phase_nxt = (rem_nxt != 32'd0) ? PH_TAG : PH_SUBTAG;
            end
          end
        end
        PH_TAG: begin
          tag_nxt = b;
          if (rem_r != 32'd0)
            rem_nxt = rem_r - 32'd1;
          acc_nxt    = 64'd0;
          vshift_nxt = 7'd0;
          phase_nxt  = (b == arch_tag_r) ? PH_STRING : PH_ULEB;
          if (in_tlast) begin
            kind  = (b == arch_tag_r) ? K_SEND : K_NUM;
            tag_o = b;
          end
        end
        PH_STRING: begin
          if (rem_r == 32'd0) begin
            kind       = K_ERR;
            halted_nxt = 1'b1;
          end else begin
            rem_nxt = rem_r - 32'd1;
            tag_o   = tag_r;
            if (b != 8'd0) begin
              kind = K_SCHAR;
              ch_o = b;
            end else begin
              kind      = K_SEND;
              phase_nxt = (rem_nxt != 32'd0) ? PH_TAG : PH_SUBTAG;
            end
          end
        end
        PH_ULEB: begin
          if (rem_r == 32'd0) begin
            kind       = K_ERR;
            halted_nxt = 1'b1;
          end else begin
            rem_nxt = rem_r - 32'd1;
            if (!vshift_r[6])
              acc_nxt = acc_r | ({57'd0, b[6:0]} << vshift_r[5:0]);
            vshift_nxt = vshift_r + ULEB_STEP;
            if (!b[7] || vshift_nxt[6] || in_tlast) begin
              kind      = K_NUM;
              tag_o     = tag_r;
              val_o     = acc_nxt;
              phase_nxt = (rem_nxt != 32'd0) ? PH_TAG : PH_SUBTAG;
            end
          end
        end
        default: begin
          kind       = K_ERR;
          halted_nxt = 1'b1;
        end
      endcase
    end

    if (in_tlast && kind == K_NONE)
      kind = K_ENDONLY;

    if (in_tlast) begin
      phase_nxt  = PH_FORMAT;
      fbc_nxt    = 3'd0;
      len_nxt    = 32'd0;
      rem_nxt    = 32'd0;
      tag_nxt    = 8'd0;
      acc_nxt    = 64'd0;
      vshift_nxt = 7'd0;
      halted_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      le_r       <= 1'b1;
      arch_tag_r <= 8'd5;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_LITTLE_ENDIAN)
        le_r <= cfg_data[0];
      else if (cfg_index == CFG_ARCH_TAG)
        arch_tag_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FORMAT;
      fbc_r    <= 3'd0;
      len_r    <= 32'd0;
      rem_r    <= 32'd0;
      tag_r    <= 8'd0;
      subtag_r <= 8'd0;
      acc_r    <= 64'd0;
      vshift_r <= 7'd0;
      halted_r <= 1'b0;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      fbc_r    <= fbc_nxt;
      len_r    <= len_nxt;
      rem_r    <= rem_nxt;
      tag_r    <= tag_nxt;
      subtag_r <= in_tlast ? 8'd0 : subtag_nxt;
      acc_r    <= acc_nxt;
      vshift_r <= vshift_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_data_r <= {subtag_nxt, val_o, ch_o, tag_o};
      out_kind_r <= kind;
      out_last_r <= in_tlast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> phase_r == PH_FORMAT && !halted_r && subtag_r == 8'd0)
    else $error("state not cleared after last item");

  a_fbc_range: assert property (@(posedge clk) disable iff (!rst_n)
    !fbc_r[2])
    else $error("field byte count out of range");

  a_no_none_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != K_NONE)
    else $error("empty result kind on output");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  a_last_always_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> out_tvalid && out_tlast)
    else $error("last item produced no result");

endmodule

// ===== test/tb_riscv_attribute_section_parser.sv =====
`timescale 1ns / 100ps

module tb_riscv_attribute_section_parser;
  import rvattr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1500;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tag_id;
    logic [7:0]  char_out;
    logic [63:0] num_value;
    logic [7:0]  sub_tag;
    logic        section_end;
  } parse_result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tlast;
  logic cfg_valid;
  logic cfg_ready;
  logic [7:0] cfg_index;
  logic [7:0] cfg_data;

  riscv_attribute_section_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // parser mirror
  logic        le_cfg;
  logic [7:0]  arch_cfg;
  phase_t      ph;
  logic [2:0]  fcnt;
  logic [31:0] len_acc;
  logic [31:0] sub_left;
  logic [7:0]  cur_tag;
  logic [7:0]  cur_sub;
  logic [63:0] uleb_acc;
  logic [6:0]  uleb_shift;
  logic        halt;

  parse_result_t pending_results[$];
  logic [7:0] sect[$];
  int fails = 0;
  int sent_items = 0;
  int idle_cycles = 0;
  int rx_wait = 0;
  int rx_taken = 0;
  int rx_seen = 0;
  bit tx_burst = 0;
  bit rx_burst = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic clear_parse();
    ph = PH_FORMAT;
    fcnt = '0;
    len_acc = '0;
    sub_left = '0;
    cur_tag = '0;
    cur_sub = '0;
    uleb_acc = '0;
    uleb_shift = '0;
    halt = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic lst);
    kind_t k;
    logic [7:0] tg;
    logic [7:0] ch;
    logic [63:0] v;
    parse_result_t r;
    k = K_NONE;
    tg = '0;
    ch = '0;
    v = '0;
    if (!halt) begin
      case (ph)
        PH_FORMAT: begin
          if (b == FORMAT_BYTE) begin
            ph = PH_SECLEN;
            fcnt = '0;
          end else begin
            k = K_ERR;
            halt = 1'b1;
          end
        end
        PH_SECLEN: begin
          fcnt = fcnt + 3'd1;
          if (fcnt >= 3'd4) begin
            fcnt = '0;
            ph = PH_VENDOR;
          end
        end
        PH_VENDOR: begin
          if (b != 8'd0) begin
            k = K_VCHAR;
            ch = b;
          end else begin
            k = K_VEND;
            ph = PH_SUBTAG;
          end
        end
        PH_SUBTAG: begin
          cur_sub = b;
          len_acc = '0;
          fcnt = '0;
          ph = PH_SUBLEN;
        end
        PH_SUBLEN: begin
          if (le_cfg) len_acc = len_acc | ({24'd0, b} << (8 * fcnt[1:0]));
          else len_acc = {len_acc[23:0], b};
          fcnt = fcnt + 3'd1;
          if (fcnt >= 3'd4) begin
            fcnt = '0;
            if (len_acc < MIN_SUB_LEN) begin
              k = K_ERR;
              halt = 1'b1;
            end else begin
              sub_left = len_acc - MIN_SUB_LEN;
              ph = (sub_left != 0) ? PH_TAG : PH_SUBTAG;
            end
          end
        end
        PH_TAG: begin
          cur_tag = b;
          if (sub_left != 0) sub_left = sub_left - 1;
          uleb_acc = '0;
          uleb_shift = '0;
          ph = (b == arch_cfg) ? PH_STRING : PH_ULEB;
          if (lst) begin
            k = (b == arch_cfg) ? K_SEND : K_NUM;
            tg = b;
          end
        end
        PH_STRING: begin
          if (sub_left == 0) begin
            k = K_ERR;
            halt = 1'b1;
          end else begin
            sub_left = sub_left - 1;
            tg = cur_tag;
            if (b != 8'd0) begin
              k = K_SCHAR;
              ch = b;
            end else begin
              k = K_SEND;
              ph = (sub_left != 0) ? PH_TAG : PH_SUBTAG;
            end
          end
        end
        PH_ULEB: begin
          if (sub_left == 0) begin
            k = K_ERR;
            halt = 1'b1;
          end else begin
            sub_left = sub_left - 1;
            if (uleb_shift < 7'd64) uleb_acc = uleb_acc | ({57'd0, b[6:0]} << uleb_shift);
            uleb_shift = uleb_shift + ULEB_STEP;
            if (!b[7] || uleb_shift >= 7'd64 || lst) begin
              k = K_NUM;
              tg = cur_tag;
              v = uleb_acc;
              ph = (sub_left != 0) ? PH_TAG : PH_SUBTAG;
            end
          end
        end
        default: begin
          k = K_ERR;
          halt = 1'b1;
        end
      endcase
    end
    if (lst && k == K_NONE) k = K_ENDONLY;
    if (k != K_NONE) begin
      r.kind = k;
      r.tag_id = tg;
      r.char_out = ch;
      r.num_value = v;
      r.sub_tag = cur_sub;
      r.section_end = lst;
      pending_results = {pending_results, r};
    end
    if (lst) clear_parse();
  endtask

  task automatic push_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_byte(b, lst);
    sent_items++;
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    wait_all_results();
    repeat (3) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_LITTLE_ENDIAN) le_cfg = val[0];
    else if (idx == CFG_ARCH_TAG) arch_cfg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic put_length(input logic [31:0] len);
    if (le_cfg) begin
      sect = {sect, len[7:0], len[15:8], len[23:16], len[31:24]};
    end else begin
      sect = {sect, len[31:24], len[23:16], len[15:8], len[7:0]};
    end
  endtask

  // mostly well-formed sections with random content, some broken ones
  task automatic build_section();
    logic [7:0] body[$];
    logic [31:0] len;
    logic [7:0] tg;
    int n;
    int nsub;
    int nattr;
    sect.delete();
    sect = {sect, (($urandom_range(0, 15) == 0) ? 8'($urandom) : FORMAT_BYTE)};
    repeat (4) sect = {sect, 8'($urandom)};
    n = $urandom_range(0, 4);
    repeat (n) sect = {sect, 8'($urandom_range(1, 255))};
    sect = {sect, 8'd0};
    nsub = $urandom_range(1, 3);
    repeat (nsub) begin
      body.delete();
      nattr = $urandom_range(0, 4);
      repeat (nattr) begin
        tg = ($urandom_range(0, 2) == 0) ? arch_cfg : 8'($urandom);
        body = {body, tg};
        if (tg == arch_cfg) begin
          n = $urandom_range(0, 4);
          repeat (n) body = {body, 8'($urandom_range(1, 255))};
          body = {body, 8'd0};
        end else begin
          n = ($urandom_range(0, 7) == 0) ? 10 : $urandom_range(1, 3);
          repeat (n - 1) body = {body, 8'($urandom) | 8'h80};
          body = {body, ((n == 10) ? 8'($urandom) : (8'($urandom) & 8'h7F))};
        end
      end
      len = MIN_SUB_LEN + body.size();
      case ($urandom_range(0, 19))
        0, 1: len = $urandom_range(0, 4);
        2, 3: len = MIN_SUB_LEN + $urandom_range(0, body.size());
        4: len = $urandom;
        default: ;
      endcase
      sect = {sect, 8'($urandom)};
      put_length(len);
      foreach (body[j]) sect = {sect, body[j]};
    end
  endtask

  task automatic test_bad_format();
    push_byte(8'h00, 1'b0);
    push_byte(FORMAT_BYTE, 1'b0);
    push_byte(8'hFF, 1'b1);
  endtask

  // vendor name, empty subsection, 64-bit value, string cut by the section end
  task automatic test_long_value_and_cut();
    push_byte(FORMAT_BYTE, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    wait_all_results();
    push_byte(8'h01, 1'b0);
    push_byte(8'h05, 1'b0);
    repeat (3) push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h12, 1'b0);
    repeat (3) push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    repeat (10) push_byte(8'hFF, 1'b0);
    push_byte(arch_cfg, 1'b0);
    push_byte(8'h78, 1'b1);
  endtask

  task automatic test_short_length();
    push_byte(FORMAT_BYTE, 1'b0);
    repeat (4) push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h04, 1'b0);
    repeat (3) push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
  endtask

  task automatic test_overrun_big_endian();
    write_reg(CFG_LITTLE_ENDIAN, 8'h00);
    write_reg(CFG_ARCH_TAG, 8'h00);
    push_byte(FORMAT_BYTE, 1'b0);
    repeat (4) push_byte(8'h00, 1'b0);
    push_byte(8'h76, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    repeat (3) push_byte(8'h00, 1'b0);
    push_byte(8'h06, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h71, 1'b0);
    push_byte(8'h7F, 1'b1);
  endtask

  task automatic test_unused_register();
    write_reg(8'h02, 8'hFF);
    write_reg(8'hFF, 8'h00);
  endtask

  task automatic test_random_sections(input logic le, input logic [7:0] arch, input int items);
    int target;
    int cut;
    write_reg(CFG_LITTLE_ENDIAN, {7'($urandom), le});
    write_reg(CFG_ARCH_TAG, arch);
    target = sent_items + items;
    while (sent_items < target) begin
      tx_burst = ($urandom_range(0, 7) == 0);
      rx_burst = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 14) == 0) begin
        sect.delete();
        repeat ($urandom_range(1, 20)) sect = {sect, 8'($urandom)};
      end else begin
        build_section();
      end
      cut = sect.size() - 1;
      if ($urandom_range(0, 5) == 0) cut = $urandom_range(0, sect.size() - 1);
      for (int i = 0; i <= cut; i++) begin
        if ($urandom_range(0, 299) == 0) wait_all_results();
        push_byte(sect[i], i == cut);
      end
    end
    tx_burst = 0;
    rx_burst = 0;
  endtask

  always @(negedge clk) begin
    if (rx_taken != rx_seen) begin
      rx_seen = rx_taken;
      rx_wait = rx_burst ? 0 : $urandom_range(0, 14);
    end
    if (rx_wait > 0) begin
      out_tready <= 1'b0;
      rx_wait = rx_wait - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    parse_result_t got;
    parse_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      rx_taken++;
      got.kind = kind_t'(out_tuser);
      got.tag_id = out_tdata[7:0];
      got.char_out = out_tdata[15:8];
      got.num_value = out_tdata[79:16];
      got.sub_tag = out_tdata[87:80];
      got.section_end = out_tlast;
      if (pending_results.size() == 0) begin
        $error("unexpected result item: kind %0d", got.kind);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, got.kind);
          fails++;
        end
        if (got.tag_id !== want.tag_id) begin
          $error("tag_id: expected %0h, actual %0h", want.tag_id, got.tag_id);
          fails++;
        end
        if (got.char_out !== want.char_out) begin
          $error("char_out: expected %0h, actual %0h", want.char_out, got.char_out);
          fails++;
        end
        if (got.num_value !== want.num_value) begin
          $error("num_value: expected %0h, actual %0h", want.num_value, got.num_value);
          fails++;
        end
        if (got.sub_tag !== want.sub_tag) begin
          $error("sub_tag: expected %0h, actual %0h", want.sub_tag, got.sub_tag);
          fails++;
        end
        if (got.section_end !== want.section_end) begin
          $error("section_end: expected %0d, actual %0d", want.section_end, got.section_end);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_riscv_attribute_section_parser failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    le_cfg = 1'b1;
    arch_cfg = 8'd5;
    clear_parse();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_bad_format();
    test_long_value_and_cut();
    test_short_length();
    test_overrun_big_endian();
    test_unused_register();
    test_random_sections(1'b1, 8'd5, RANDOM_ITEMS / 4);
    test_random_sections(1'b0, 8'd0, RANDOM_ITEMS / 4);
    test_random_sections(1'b1, 8'd255, RANDOM_ITEMS / 4);
    test_random_sections(1'b0, 8'($urandom), RANDOM_ITEMS / 4);

    wait_all_results();
    repeat (5) @(negedge clk);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("tb_riscv_attribute_section_parser passed");
    end else begin
      $display("tb_riscv_attribute_section_parser failed");
    end
    $finish;
  end

endmodule
